@@ rtl/topd_pkg.sv @@
// Types and constants for the tone onset and peak detector.
// No dependencies; imported by the top level.
package topd_pkg;

   localparam int TIME_WIDTH      = 32;
   localparam int LEVEL_WIDTH     = 32;
   localparam int BIN_WIDTH       = 2;
   localparam int MAG_IN_WIDTH    = 16;
   localparam int NUM_IN_BINS     = 4;
   localparam int THRESH_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic KIND_ARM  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DETECT_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PEAK_WINDOW      = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RISING_EDGE_MODE = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INTEGRATE_MODE   = 8'd3;

   localparam logic [THRESH_WIDTH-1:0] THRESHOLD_RESET = 16'd1000;
   localparam logic [TIME_WIDTH-1:0]   WINDOW_RESET    = 32'd10000;

   typedef struct packed {
      logic                    kind;
      logic [TIME_WIDTH-1:0]   time_us;
      logic [MAG_IN_WIDTH-1:0] mag_0;
      logic [MAG_IN_WIDTH-1:0] mag_1;
      logic [MAG_IN_WIDTH-1:0] mag_2;
      logic [MAG_IN_WIDTH-1:0] mag_3;
   } req_data_type;

   typedef struct packed {
      logic                   found;
      logic [TIME_WIDTH-1:0]  peak_time;
      logic [BIN_WIDTH-1:0]   tone_bin;
      logic [LEVEL_WIDTH-1:0] tone_level;
   } rsp_data_type;

endpackage

@@ rtl/tone_onset_peak_detector.sv @@
// Tone onset and peak detector over per-tick frequency-bin magnitudes.
// Depends on topd_pkg for the request and response types and register indices.
//
// An arm request records the listen start time and clears detection state and
// returns nothing; each tick request returns one response in the cycle after it
// is taken. One request is taken every cycle: the bin scan, the per-bin sums
// and the window check all settle in a single pass between the request handshake
// and the response register, and req_ready only drops while a response sits
// in that register and rsp_ready is low. Configuration writes are always taken.
module tone_onset_peak_detector #(
   parameter int NUM_BINS = 4,
   parameter int MAG_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  topd_pkg::req_data_type                  req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output topd_pkg::rsp_data_type                  rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [topd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [topd_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import topd_pkg::*;

   localparam int SCAN_BINS = (NUM_BINS < NUM_IN_BINS) ? NUM_BINS : NUM_IN_BINS;
   localparam int MW        = (MAG_BITS < MAG_IN_WIDTH) ? MAG_BITS : MAG_IN_WIDTH;

   // configuration
   logic [THRESH_WIDTH-1:0] threshold_ff;
   logic [TIME_WIDTH-1:0]   window_ff;
   logic                    rising_ff;
   logic                    integrate_ff;

   // detection state
   logic [TIME_WIDTH-1:0]   listen_start_ff, listen_start_in;
   logic [TIME_WIDTH-1:0]   window_end_ff, window_end_in;
   logic [TIME_WIDTH-1:0]   peak_stamp_ff, peak_stamp_in;
   logic [BIN_WIDTH-1:0]    best_bin_ff, best_bin_in;
   logic [LEVEL_WIDTH-1:0]  best_level_ff, best_level_in;
   logic                    detected_ff, detected_in;
   logic [LEVEL_WIDTH-1:0]  sums_ff [SCAN_BINS];
   logic [LEVEL_WIDTH-1:0]  sums_in [SCAN_BINS];

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_data_type            rsp_data_ff, rsp_data_in;

   logic [MAG_IN_WIDTH-1:0] mag_raw [NUM_IN_BINS];
   logic [LEVEL_WIDTH-1:0]  mag_ext [SCAN_BINS];
   logic [TIME_WIDTH-1:0]   now;
   logic [TIME_WIDTH:0]     end_wide;
   logic [TIME_WIDTH-1:0]   end_sat;
   logic                    req_fire, arm_go, tick_go, tick_active;

   // scan results
   logic [LEVEL_WIDTH-1:0]  scan_level;
   logic [BIN_WIDTH-1:0]    scan_bin;
   logic                    scan_det;
   logic [TIME_WIDTH-1:0]   scan_stamp;
   logic [TIME_WIDTH-1:0]   scan_wend;

   // post-scan results
   logic [LEVEL_WIDTH-1:0]  sums_next [SCAN_BINS];
   logic [LEVEL_WIDTH:0]    sum_wide;
   logic [LEVEL_WIDTH-1:0]  fin_level;
   logic [BIN_WIDTH-1:0]    fin_bin;
   logic                    found;

   assign now        = req_data.time_us;
   assign mag_raw[0] = req_data.mag_0;
   assign mag_raw[1] = req_data.mag_1;
   assign mag_raw[2] = req_data.mag_2;
   assign mag_raw[3] = req_data.mag_3;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign arm_go      = req_fire && (req_data.kind == KIND_ARM);
   assign tick_go     = req_fire && (req_data.kind == KIND_TICK);
   assign tick_active = tick_go && (now >= listen_start_ff);

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // saturating window end
   assign end_wide = {1'b0, now} + {1'b0, window_ff};
   assign end_sat  = end_wide[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : end_wide[TIME_WIDTH-1:0];

   always_comb begin
      for (int i = 0; i < SCAN_BINS; i++) begin
         mag_ext[i] = LEVEL_WIDTH'(mag_raw[i][MW-1:0]);
      end
   end

   // running maximum over the bins in order
   always_comb begin
      scan_level = best_level_ff;
      scan_bin   = best_bin_ff;
      scan_det   = detected_ff;
      scan_stamp = peak_stamp_ff;
      scan_wend  = window_end_ff;
      for (int i = 0; i < SCAN_BINS; i++) begin
         if (mag_ext[i] > scan_level) begin
            scan_level = mag_ext[i];
            scan_bin   = BIN_WIDTH'(i);
            if (!scan_det && (scan_level > LEVEL_WIDTH'(threshold_ff))) begin
               scan_det   = 1'b1;
               scan_stamp = now;
               scan_wend  = end_sat;
            end
            if (!rising_ff) begin
               scan_stamp = now;
            end
         end
      end
   end

   // integration and window expiry
   always_comb begin
      sum_wide  = '0;
      fin_level = scan_level;
      fin_bin   = scan_bin;
      found     = 1'b0;
      for (int i = 0; i < SCAN_BINS; i++) begin
         sums_next[i] = sums_ff[i];
         if (scan_det && integrate_ff) begin
            sum_wide     = {1'b0, sums_ff[i]} + {1'b0, mag_ext[i]};
            sums_next[i] = sum_wide[LEVEL_WIDTH] ? {LEVEL_WIDTH{1'b1}}
                                                 : sum_wide[LEVEL_WIDTH-1:0];
         end
      end
      if (scan_det && (now >= scan_wend)) begin
         found = 1'b1;
         if (integrate_ff) begin
            fin_level = '0;
            for (int i = 0; i < SCAN_BINS; i++) begin
               if (sums_next[i] > fin_level) begin
                  fin_level = sums_next[i];
                  fin_bin   = BIN_WIDTH'(i);
               end
            end
         end
      end
   end

   always_comb begin
      listen_start_in = listen_start_ff;
      window_end_in   = window_end_ff;
      peak_stamp_in   = peak_stamp_ff;
      best_bin_in     = best_bin_ff;
      best_level_in   = best_level_ff;
      detected_in     = detected_ff;
      for (int i = 0; i < SCAN_BINS; i++) begin
         sums_in[i] = sums_ff[i];
      end
      if (arm_go) begin
         listen_start_in = now;
         window_end_in   = {TIME_WIDTH{1'b1}};
         peak_stamp_in   = '0;
         best_bin_in     = '0;
         best_level_in   = '0;
         detected_in     = 1'b0;
         for (int i = 0; i < SCAN_BINS; i++) begin
            sums_in[i] = '0;
         end
      end else if (tick_active) begin
         window_end_in = scan_wend;
         peak_stamp_in = scan_stamp;
         best_bin_in   = fin_bin;
         best_level_in = fin_level;
         detected_in   = scan_det;
         for (int i = 0; i < SCAN_BINS; i++) begin
            sums_in[i] = sums_next[i];
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (tick_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (tick_active && found) begin
            rsp_data_in.found      = 1'b1;
            rsp_data_in.peak_time  = scan_stamp;
            rsp_data_in.tone_bin   = fin_bin;
            rsp_data_in.tone_level = fin_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         window_ff       <= WINDOW_RESET;
         rising_ff       <= 1'b1;
         integrate_ff    <= 1'b0;
         listen_start_ff <= '0;
         window_end_ff   <= {TIME_WIDTH{1'b1}};
         peak_stamp_ff   <= '0;
         best_bin_ff     <= '0;
         best_level_ff   <= '0;
         detected_ff     <= 1'b0;
         for (int i = 0; i < SCAN_BINS; i++) begin
            sums_ff[i] <= '0;
         end
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_DETECT_THRESHOLD: threshold_ff <= csr_data[THRESH_WIDTH-1:0];
               REG_PEAK_WINDOW:      window_ff    <= csr_data[TIME_WIDTH-1:0];
               REG_RISING_EDGE_MODE: rising_ff    <= csr_data[0];
               REG_INTEGRATE_MODE:   integrate_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         listen_start_ff <= listen_start_in;
         window_end_ff   <= window_end_in;
         peak_stamp_ff   <= peak_stamp_in;
         best_bin_ff     <= best_bin_in;
         best_level_ff   <= best_level_in;
         detected_ff     <= detected_in;
         for (int i = 0; i < SCAN_BINS; i++) begin
            sums_ff[i] <= sums_in[i];
         end
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
